[hw/rtl/swm_pkg.sv]
// Shared types and constants for the sliding-window maximum filter.
`timescale 1ns / 1ps

package swm_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CFG_W    = 7;

    localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd3;

    // Per-cycle control broadcast to every cell of the candidate chain.
    typedef struct packed {
        logic shift;   // front cell has aged out: every cell takes its neighbor
        logic accept;  // a new sample is taken this cycle
        logic last;    // the sample ends the array: clear after this step
    } t_cell_ctl;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] window_max;
        logic                       array_end;
    } t_result;

endpackage

[hw/rtl/swm_ifs.sv]
// Channel interfaces: sample input, result output and window size write.
`timescale 1ns / 1ps

interface swm_smp_if import swm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                       last_sample;

    modport source (output valid, output sample_value, output last_sample, input ready);
    modport sink   (input valid, input sample_value, input last_sample, output ready);
endinterface

interface swm_res_if import swm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] window_max;
    logic                       array_end;

    modport source (output valid, output window_max, output array_end, input ready);
    modport sink   (input valid, input window_max, input array_end, output ready);
endinterface

interface swm_cfg_if import swm_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] window_size;

    modport source (output valid, output window_size, input ready);
    modport sink   (input valid, input window_size, output ready);
endinterface

[hw/rtl/swm_cell.sv]
// One candidate cell: holds a value and its age, shifts toward the front.
`timescale 1ns / 1ps

module swm_cell import swm_pkg::*; #(
    parameter int AW = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cell_ctl                  i_ctl,
    input  logic signed [SAMPLE_W-1:0] i_x,
    input  logic                       i_prev_keep,
    input  logic                       i_nxt_valid,
    input  logic signed [SAMPLE_W-1:0] i_nxt_value,
    input  logic [AW-1:0]              i_nxt_age,
    output logic                       o_valid,
    output logic signed [SAMPLE_W-1:0] o_value,
    output logic [AW-1:0]              o_age,
    output logic                       o_keep
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_value;
    logic [AW-1:0]              r_age;
    logic                       n_valid;
    logic signed [SAMPLE_W-1:0] n_value;
    logic [AW-1:0]              n_age;
    logic                       src_valid;
    logic signed [SAMPLE_W-1:0] src_value;
    logic [AW-1:0]              src_age;
    logic                       keep;

    always_comb begin
        src_valid = i_ctl.shift ? i_nxt_valid : r_valid;
        src_value = i_ctl.shift ? i_nxt_value : r_value;
        src_age   = i_ctl.shift ? i_nxt_age   : r_age;
        keep      = src_valid && (src_value > i_x);
    end

    always_comb begin
        n_valid = src_valid;
        n_value = src_value;
        n_age   = src_age;
        if (i_ctl.accept) begin
            if (keep) begin
                n_age = src_age + AW'(1);
            end else if (i_prev_keep) begin
                // first slot past the survivors takes the new sample
                n_valid = 1'b1;
                n_value = i_x;
                n_age   = AW'(1);
            end else begin
                n_valid = 1'b0;
            end
            if (i_ctl.last) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_valid = r_valid;
    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_keep  = keep;

endmodule

[hw/rtl/swm_out_buf.sv]
// Two-entry result buffer: output register plus skid entry.
`timescale 1ns / 1ps

module swm_out_buf import swm_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_result      i_data,
    output logic         o_full,
    swm_res_if.source    o_res
);

    t_result r_head;
    t_result r_skid;
    logic    r_head_valid;
    logic    r_skid_valid;
    t_result n_head;
    t_result n_skid;
    logic    n_head_valid;
    logic    n_skid_valid;
    logic    pop;

    assign pop = r_head_valid && o_res.ready;

    always_comb begin
        n_head       = r_head;
        n_skid       = r_skid;
        n_head_valid = r_head_valid;
        n_skid_valid = r_skid_valid;
        if (pop) begin
            if (r_skid_valid) begin
                n_head       = r_skid;
                n_skid       = i_data;
                n_skid_valid = i_push;
            end else begin
                n_head       = i_data;
                n_head_valid = i_push;
            end
        end else if (i_push) begin
            if (r_head_valid) begin
                n_skid       = i_data;
                n_skid_valid = 1'b1;
            end else begin
                n_head       = i_data;
                n_head_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_head_valid <= n_head_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_skid <= n_skid;
    end

    assign o_full           = r_skid_valid;
    assign o_res.valid      = r_head_valid;
    assign o_res.window_max = r_head.window_max;
    assign o_res.array_end  = r_head.array_end;

`ifndef NO_ASSERTIONS
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_head_valid)
        else $error("skid entry held without a head entry");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !o_res.ready |=> r_skid_valid && $stable(r_skid))
        else $error("skid entry lost while output stalled");
`endif

endmodule

[hw/rtl/sliding_window_maximum_top.sv]
// Top level of the streaming sliding-window maximum filter.
`timescale 1ns / 1ps

// Usage:
//   i_smp carries one signed sample per transaction with a last_sample flag
//   that closes the current array. o_res returns window_max, the maximum of
//   the latest window_size samples, and array_end, set on the result of the
//   array's final sample. No result is sent until window_size samples of the
//   array have arrived; the last sample still clears the array state then.
//   i_cfg writes window_size (0 acts as 1, values above WINDOW_MAX saturate);
//   write it only while no sample is in flight.
//   Throughput: one sample per cycle while the result buffer has room. After
//   window_size is lowered, each candidate beyond the first that falls out
//   of the shorter window holds i_smp.ready low, since only the front cell
//   of the chain can retire per cycle.
//   Reset clears every candidate, the sample count and sets window_size to 3.
//   A stalled o_res is absorbed by a two-entry buffer; the stall drops i_smp.ready
//   only once both entries are occupied, never through a path from o_res.ready.
module sliding_window_maximum_top import swm_pkg::*; #(
    parameter int WINDOW_MAX = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    swm_smp_if.sink   i_smp,
    swm_cfg_if.sink   i_cfg,
    swm_res_if.source o_res
);

    localparam int AW_WIN = $clog2(WINDOW_MAX + 1);
    localparam int AW     = (AW_WIN > CFG_W) ? AW_WIN : CFG_W;

    logic [CFG_W-1:0] r_window_size;
    logic [AW-1:0]    r_pos;
    logic             r_filled;
    logic [AW-1:0]    win;
    logic [AW:0]      pos_inc;
    logic             reach;
    logic             exp0;
    logic             exp1;
    logic             buf_full;
    logic             accept;
    t_cell_ctl        ctl;
    t_result          res;
    logic signed [SAMPLE_W-1:0] src0_value;

    // Index WINDOW_MAX is a permanently empty pad behind the last cell.
    logic                       c_valid [WINDOW_MAX+1];
    logic signed [SAMPLE_W-1:0] c_value [WINDOW_MAX+1];
    logic [AW-1:0]              c_age   [WINDOW_MAX+1];
    logic                       c_keep  [WINDOW_MAX+1];
    logic [WINDOW_MAX-1:0]      valid_vec;

    // Clamp the window size into 1..WINDOW_MAX.
    always_comb begin
        win = AW'(r_window_size);
        if (r_window_size == '0) begin
            win = AW'(1);
        end else if (AW'(r_window_size) > AW'(WINDOW_MAX)) begin
            win = AW'(WINDOW_MAX);
        end
    end

    // Ages count from the next sample's position, so the front expires
    // once its age reaches the window.
    assign exp0 = c_valid[0] && (c_age[0] >= win);
    assign exp1 = c_valid[1] && (c_age[1] >= win);

    assign i_smp.ready = !(exp0 && exp1) && !buf_full;
    assign accept      = i_smp.valid && i_smp.ready;
    assign i_cfg.ready = 1'b1;

    // Retire an aged-out front only while a sample is offered, so a window
    // write applies from the next sample on.
    always_comb begin
        ctl.shift  = exp0 && i_smp.valid;
        ctl.accept = accept;
        ctl.last   = i_smp.last_sample;
    end

    assign c_valid[WINDOW_MAX] = 1'b0;
    assign c_value[WINDOW_MAX] = '0;
    assign c_age[WINDOW_MAX]   = '0;
    assign c_keep[0]           = 1'b1;

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        swm_cell #(.AW(AW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl),
            .i_x         (i_smp.sample_value),
            .i_prev_keep (c_keep[i]),
            .i_nxt_valid (c_valid[i+1]),
            .i_nxt_value (c_value[i+1]),
            .i_nxt_age   (c_age[i+1]),
            .o_valid     (c_valid[i]),
            .o_value     (c_value[i]),
            .o_age       (c_age[i]),
            .o_keep      (c_keep[i+1])
        );
        assign valid_vec[i] = c_valid[i];
    end

    // The new front is the surviving head, or the new sample if none survives.
    assign src0_value = exp0 ? c_value[1] : c_value[0];
    assign pos_inc    = {1'b0, r_pos} + (AW+1)'(1);
    assign reach      = pos_inc >= {1'b0, win};

    always_comb begin
        res.window_max = c_keep[1] ? src0_value : i_smp.sample_value;
        res.array_end  = i_smp.last_sample;
    end

    swm_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (r_filled || reach)),
        .i_data  (res),
        .o_full  (buf_full),
        .o_res   (o_res)
    );

    // Sample count and sticky fill flag; the count may wrap once filled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= WINDOW_SIZE_RESET;
            r_pos         <= '0;
            r_filled      <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                r_window_size <= i_cfg.window_size;
            end
            if (accept) begin
                if (i_smp.last_sample) begin
                    r_pos    <= '0;
                    r_filled <= 1'b0;
                end else begin
                    r_pos    <= pos_inc[AW-1:0];
                    r_filled <= r_filled || reach;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_smp.last_sample |=> valid_vec == '0)
        else $error("candidates survive the end of an array");
    a_front_after_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_smp.last_sample |=> c_valid[0])
        else $error("no front candidate after a sample");
    a_packed_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((valid_vec + WINDOW_MAX'(1)) & valid_vec) == '0)
        else $error("candidate chain has a gap");
    a_first_sample_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_smp.last_sample |=> r_pos == '0 && !r_filled)
        else $error("array state not cleared");
`endif

endmodule
